[rtl/cttok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttok_pkg: shared types and codes of the config text tokenizer
// Lexer modes, event and token codes, character constants and the result
// word layout used between the lexer step logic and the top level.
// ----------------------------------------------------------------------------
package cttok_pkg;

	// lexer modes
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_WORD    = 2'd2,
		MODE_STRING  = 2'd3
	} mode_t;

	// event kinds
	localparam logic [2:0] EV_PUNCT = 3'd0;
	localparam logic [2:0] EV_CHAR  = 3'd1;
	localparam logic [2:0] EV_END   = 3'd2;
	localparam logic [2:0] EV_ERROR = 3'd3;
	localparam logic [2:0] EV_DONE  = 3'd4;

	// token types
	localparam logic [3:0] TT_LBRACK = 4'd0;
	localparam logic [3:0] TT_RBRACK = 4'd1;
	localparam logic [3:0] TT_LBRACE = 4'd2;
	localparam logic [3:0] TT_RBRACE = 4'd3;
	localparam logic [3:0] TT_EQUAL  = 4'd4;
	localparam logic [3:0] TT_COMMA  = 4'd5;
	localparam logic [3:0] TT_DOT    = 4'd6;
	localparam logic [3:0] TT_WORD   = 4'd7;
	localparam logic [3:0] TT_STRING = 4'd8;
	localparam logic [3:0] TT_NONE   = 4'd15;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG = 2'd1;
	localparam logic [1:0] ERR_UNTERM   = 2'd2;

	// characters
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;

	// one result word
	typedef struct packed {
		logic [2:0] event_kind;
		logic [3:0] token_type;
		logic [7:0] text_byte;
		logic [6:0] token_length;
		logic [1:0] error_code;
		logic       last;
	} result_t;

	// outcome of one character in idle mode
	typedef struct packed {
		logic    emit;
		result_t res;
		mode_t   mode;
		logic [6:0] len;
	} idle_t;

	// outcome of one lexer step
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
		mode_t      mode;
		logic [6:0] len;
	} step_t;

endpackage

[rtl/cttok_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttok_if: channel interfaces of the config text tokenizer
// Character channel into the block and event channel out of it, each with
// valid/ready flow control.
// ----------------------------------------------------------------------------
interface cttok_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cttok_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [3:0] token_type;
	logic [7:0] text_byte;
	logic [6:0] token_length;
	logic [1:0] error_code;
	logic       last;

	modport source (output valid, output event_kind, output token_type, output text_byte,
		output token_length, output error_code, output last, input ready);
	modport sink   (input valid, input event_kind, input token_type, input text_byte,
		input token_length, input error_code, input last, output ready);
endinterface

[rtl/config_text_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_core: streaming lexer for a small config text format
// One character word in, zero to two event words out, through an input
// register, the lexer step logic and a two-entry result buffer.
// ----------------------------------------------------------------------------
// An accepted character is held in the input register; its events are then registered in the result buffer.
// Throughput: one character per cycle while the event channel takes each event;
//   a character that gives two events holds the input while the result buffer drains.
// Reset: mode idle, token length zero, capacity 128 (clamped to
//   MAX_TOKEN_BYTES), input register and result buffer empty.
module config_text_tokenizer_core #(
	parameter int MAX_TOKEN_BYTES = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cttok_char_if.sink           chars,
	cttok_event_if.source        events,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata
);
	import cttok_pkg::*;

	// length limit: capacity clamped to [2, MAX_TOKEN_BYTES], minus one, at most 127
	function automatic logic [6:0] calc_limit(logic [7:0] cap_in);
		int c;
		c = int'(cap_in);
		if (c > MAX_TOKEN_BYTES) c = MAX_TOKEN_BYTES;
		if (c < 2) c = 2;
		c = c - 1;
		if (c > 127) c = 127;
		return 7'(c);
	endfunction

	logic [6:0] limit_q;
	mode_t      mode_q;
	logic [6:0] len_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	result_t    res0_q;
	result_t    res1_q;
	logic [1:0] cnt_q;

	step_t      step;
	logic       fire;
	logic       out_fire;

	// capacity register, stored as the derived limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= calc_limit(8'd128);
		end else if (cfg_we) begin
			limit_q <= calc_limit(cfg_wdata);
		end
	end

	// handshakes
	assign out_fire     = events.valid && events.ready;
	assign fire         = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && events.ready));
	assign chars.ready  = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			byte_s1 <= chars.in_byte;
			eoi_s1  <= chars.end_of_input;
		end
	end

	// lexer step
	cttok_lex u_lex (
		.mode         (mode_q),
		.len          (len_q),
		.limit        (limit_q),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.step         (step)
	);

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= 7'd0;
		end else if (fire) begin
			mode_q <= step.mode;
			len_q  <= step.len;
		end
	end

	// result buffer: occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (fire) begin
			cnt_q <= step.count;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result buffer: entries, head is res0_q
	always_ff @(posedge clk) begin
		if (fire) begin
			res0_q <= step.res0;
			res1_q <= step.res1;
		end else if (out_fire) begin
			res0_q <= res1_q;
		end
	end

	// event outputs
	assign events.valid        = (cnt_q != 2'd0);
	assign events.event_kind   = res0_q.event_kind;
	assign events.token_type   = res0_q.token_type;
	assign events.text_byte    = res0_q.text_byte;
	assign events.token_length = res0_q.token_length;
	assign events.error_code   = res0_q.error_code;
	assign events.last         = res0_q.last;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer overfilled");

	a_head_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !res0_q.last)
		else $error("first of two buffered words marked last");

	a_len_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == MODE_IDLE) || (mode_q == MODE_COMMENT)) |-> (len_q == 7'd0))
		else $error("token length nonzero outside a token");

	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && eoi_s1) |=> ((mode_q == MODE_IDLE) && (len_q == 7'd0)))
		else $error("lexer not idle after end of text");

endmodule

[rtl/cttok_lex.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttok_lex: lexer step logic
// Given the current mode, token length and one character word, computes
// the next mode and length and up to two result words.
// ----------------------------------------------------------------------------
module cttok_lex (
	input  cttok_pkg::mode_t  mode,
	input  logic [6:0]        len,
	input  logic [6:0]        limit,
	input  logic [7:0]        in_byte,
	input  logic              end_of_input,
	output cttok_pkg::step_t  step
);
	import cttok_pkg::*;

	function automatic result_t mk(logic [2:0] kind, logic [3:0] ttype, logic [7:0] b,
		logic [6:0] l, logic [1:0] e);
		result_t r;
		r.event_kind   = kind;
		r.token_type   = ttype;
		r.text_byte    = b;
		r.token_length = l;
		r.error_code   = e;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_word_char(logic [7:0] c);
		return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
			((c >= CH_0) && (c <= CH_9)) || (c == CH_PLUS) || (c == CH_MINUS) ||
			(c == CH_UNDER) || (c == CH_DOT);
	endfunction

	function automatic logic [3:0] punct_type(logic [7:0] c);
		logic [3:0] t;
		case (c)
			CH_LBRACK: t = TT_LBRACK;
			CH_RBRACK: t = TT_RBRACK;
			CH_LBRACE: t = TT_LBRACE;
			CH_RBRACE: t = TT_RBRACE;
			CH_EQUAL:  t = TT_EQUAL;
			CH_COMMA:  t = TT_COMMA;
			CH_DOT:    t = TT_DOT;
			default:   t = TT_NONE;
		endcase
		return t;
	endfunction

	// idle-mode handling of one character
	function automatic idle_t idle_char(logic [7:0] c);
		idle_t      r;
		logic [3:0] p;
		p      = punct_type(c);
		r.emit = 1'b0;
		r.res  = mk(EV_PUNCT, TT_LBRACK, 8'd0, 7'd0, ERR_NONE);
		r.mode = MODE_IDLE;
		r.len  = 7'd0;
		if (is_space(c)) begin
			r.mode = MODE_IDLE;
		end else if (c == CH_HASH) begin
			r.mode = MODE_COMMENT;
		end else if (p != TT_NONE) begin
			r.emit = 1'b1;
			r.res  = mk(EV_PUNCT, p, 8'd0, 7'd0, ERR_NONE);
		end else if (c == CH_QUOTE) begin
			r.mode = MODE_STRING;
		end else begin
			r.emit = 1'b1;
			r.res  = mk(EV_CHAR, TT_WORD, c, 7'd0, ERR_NONE);
			r.mode = MODE_WORD;
			r.len  = 7'd1;
		end
		return r;
	endfunction

	idle_t   idle_r;
	result_t done_r;

	always_comb begin
		idle_r    = idle_char(in_byte);
		done_r    = mk(EV_DONE, 4'd0, 8'd0, 7'd0, ERR_NONE);
		step.count = 2'd0;
		step.res0  = done_r;
		step.res1  = done_r;
		step.mode  = mode;
		step.len   = len;
		if (end_of_input) begin
			// close any open token, then report the end of the text
			if (mode == MODE_WORD) begin
				step.res0  = mk(EV_END, TT_WORD, 8'd0, len, ERR_NONE);
				step.count = 2'd1;
			end else if (mode == MODE_STRING) begin
				step.res0  = mk(EV_ERROR, TT_STRING, 8'd0, 7'd0, ERR_UNTERM);
				step.count = 2'd1;
			end
			if (step.count == 2'd0) begin
				step.res0 = done_r;
			end else begin
				step.res1 = done_r;
			end
			step.count = step.count + 2'd1;
			step.mode  = MODE_IDLE;
			step.len   = 7'd0;
		end else begin
			unique case (mode)
				MODE_COMMENT: begin
					if (in_byte == CH_LF) step.mode = MODE_IDLE;
				end
				MODE_WORD: begin
					if (is_word_char(in_byte)) begin
						step.count = 2'd1;
						if (len >= limit) begin
							step.res0 = mk(EV_ERROR, TT_WORD, 8'd0, 7'd0, ERR_TOO_LONG);
							step.mode = MODE_IDLE;
							step.len  = 7'd0;
						end else begin
							step.res0 = mk(EV_CHAR, TT_WORD, in_byte, 7'd0, ERR_NONE);
							step.len  = len + 7'd1;
						end
					end else begin
						// word ends; the character is lexed again in idle mode
						step.res0  = mk(EV_END, TT_WORD, 8'd0, len, ERR_NONE);
						step.res1  = idle_r.res;
						step.count = idle_r.emit ? 2'd2 : 2'd1;
						step.mode  = idle_r.mode;
						step.len   = idle_r.len;
					end
				end
				MODE_STRING: begin
					step.count = 2'd1;
					if (in_byte == CH_QUOTE) begin
						step.res0 = mk(EV_END, TT_STRING, 8'd0, len, ERR_NONE);
						step.mode = MODE_IDLE;
						step.len  = 7'd0;
					end else if (in_byte == CH_LF) begin
						step.res0 = mk(EV_ERROR, TT_STRING, 8'd0, 7'd0, ERR_UNTERM);
						step.mode = MODE_IDLE;
						step.len  = 7'd0;
					end else if (len >= limit) begin
						step.res0 = mk(EV_ERROR, TT_STRING, 8'd0, 7'd0, ERR_TOO_LONG);
						step.mode = MODE_IDLE;
						step.len  = 7'd0;
					end else begin
						step.res0 = mk(EV_CHAR, TT_STRING, in_byte, 7'd0, ERR_NONE);
						step.len  = len + 7'd1;
					end
				end
				default: begin
					step.res0  = idle_r.res;
					step.count = idle_r.emit ? 2'd1 : 2'd0;
					step.mode  = idle_r.mode;
					step.len   = idle_r.len;
				end
			endcase
		end
		// mark the final word of the step
		step.res0.last = (step.count == 2'd1);
		step.res1.last = (step.count == 2'd2);
	end

endmodule
